[hw/rtl/fcte_pkg.sv]
// Shared types and constants of the cluster allocation table engine.
`timescale 1ns / 1ps

package fcte_pkg;

  localparam int unsigned LinkW    = 28;
  localparam int unsigned IndexW   = 14;
  localparam int unsigned CountW   = 14;
  localparam int unsigned StatusW  = 2;

  localparam logic [LinkW-1:0] END_OF_CHAIN = 28'hFFF_FFFF;
  localparam logic [LinkW-1:0] LINK_LIMIT   = 28'hFFF_FFF8;
  localparam logic [LinkW-1:0] FIRST_DATA   = 28'd2;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusW-1:0] ST_LOOP  = 2'd2;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_FREE  = 2'd3
  } req_kind_e;

  // Table port operation selected by the controller
  typedef enum logic [2:0] {
    MEM_NONE       = 3'd0,
    MEM_READ_IDX   = 3'd1,
    MEM_WRITE_IDX  = 3'd2,
    MEM_READ_SCAN  = 3'd3,
    MEM_WRITE_EOC  = 3'd4,
    MEM_READ_CUR   = 3'd5,
    MEM_WRITE_ZERO = 3'd6
  } mem_op_e;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_RDATA = 2'd1,
    RES_ALLOC = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [IndexW-1:0] cluster_index;
    logic [LinkW-1:0]  write_value;
  } fcte_req_t;

  typedef struct packed {
    logic [LinkW-1:0]   result_value;
    logic [StatusW-1:0] status;
  } fcte_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic               load;
    logic               scan_init;
    logic               free_init;
    mem_op_e            mem_op;
    logic               finish;
    res_sel_e           res_sel;
    logic [StatusW-1:0] status;
  } fcte_cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_kind_e req_kind;
    logic      idx_ok;
    logic      scan_hit;
    logic      scan_more;
    logic      chk_valid;
    logic      clipped;
    logic      cur_live;
    logic      cur_ok;
    logic      steps_over;
  } fcte_sts_t;

endpackage

[hw/rtl/fcte_datapath.sv]
// Datapath: table memory, request latch, scan and chain-walk registers, result register.
`timescale 1ns / 1ps

module fcte_datapath #(
  parameter int unsigned TABLE_DEPTH = 16384
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fcte_pkg::fcte_req_t                 req_i,
  input  logic                                cfg_we_i,
  input  logic [fcte_pkg::CountW-1:0]         cfg_data_i,
  input  fcte_pkg::fcte_cmd_t                 cmd_i,
  output fcte_pkg::fcte_sts_t                 sts_o,
  output fcte_pkg::fcte_rsp_t                 rsp_o,
  output logic                                done_o
);
  import fcte_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = ((AW > IndexW) ? AW : IndexW) + 1;
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);

  // Table memory and its single port
  logic [LinkW-1:0] tbl_q [TABLE_DEPTH];
  logic [LinkW-1:0] rdata_q;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_addr;
  logic [LinkW-1:0] mem_wdata;

  fcte_req_t          req_q;
  logic [CountW-1:0]  count_q;
  logic [CW-1:0]      scan_addr_q, scan_addr_d;
  logic [CW-1:0]      scan_end_q;
  logic [CW-1:0]      scan_sum;
  logic               clipped_q;
  logic               chk_valid_q;
  logic [CW-1:0]      chk_addr_q;
  logic [LinkW-1:0]   cur_q;
  logic [SW-1:0]      steps_q;
  fcte_rsp_t          rsp_q, rsp_d;
  logic               done_q;

  // Port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AW'(req_q.cluster_index);
    mem_wdata = '0;
    case (cmd_i.mem_op)
      MEM_READ_IDX: begin
        mem_re = 1'b1;
      end
      MEM_WRITE_IDX: begin
        mem_we    = 1'b1;
        mem_wdata = req_q.write_value;
      end
      MEM_READ_SCAN: begin
        mem_re   = 1'b1;
        mem_addr = AW'(scan_addr_q);
      end
      MEM_WRITE_EOC: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(chk_addr_q);
        mem_wdata = END_OF_CHAIN;
      end
      MEM_READ_CUR: begin
        mem_re   = 1'b1;
        mem_addr = AW'(cur_q);
      end
      MEM_WRITE_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = AW'(cur_q);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= tbl_q[mem_addr];
    end
  end

  // Scan bound: data clusters start at index 2, clipped to the table
  assign scan_sum    = CW'(count_q) + CW'(FIRST_DATA);
  assign scan_addr_d = scan_addr_q + CW'(1);

  // Result selection
  always_comb begin
    rsp_d.status = cmd_i.status;
    case (cmd_i.res_sel)
      RES_RDATA: rsp_d.result_value = rdata_q;
      RES_ALLOC: rsp_d.result_value = LinkW'(chk_addr_q);
      default:   rsp_d.result_value = '0;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scan_init) begin
      scan_addr_q <= CW'(FIRST_DATA);
      if (scan_sum > CW'(TABLE_DEPTH)) begin
        scan_end_q <= CW'(TABLE_DEPTH);
        clipped_q  <= 1'b1;
      end else begin
        scan_end_q <= scan_sum;
        clipped_q  <= 1'b0;
      end
    end else if (cmd_i.mem_op == MEM_READ_SCAN) begin
      scan_addr_q <= scan_addr_d;
    end
    if (cmd_i.mem_op == MEM_READ_SCAN) begin
      chk_addr_q <= scan_addr_q;
    end
    if (cmd_i.free_init) begin
      cur_q   <= LinkW'(req_q.cluster_index);
      steps_q <= '0;
    end else if (cmd_i.mem_op == MEM_WRITE_ZERO) begin
      cur_q   <= rdata_q;
      steps_q <= steps_q + SW'(1);
    end
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      chk_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      chk_valid_q <= (cmd_i.mem_op == MEM_READ_SCAN);
      done_q      <= cmd_i.finish;
    end
  end

  // Status back to the controller
  assign sts_o.req_kind   = req_kind_e'(req_q.req_type);
  assign sts_o.idx_ok     = 32'(req_q.cluster_index) < 32'(TABLE_DEPTH);
  assign sts_o.scan_hit   = chk_valid_q && (rdata_q == '0);
  assign sts_o.scan_more  = scan_addr_q < scan_end_q;
  assign sts_o.chk_valid  = chk_valid_q;
  assign sts_o.clipped    = clipped_q;
  assign sts_o.cur_live   = (cur_q >= FIRST_DATA) && (cur_q < LINK_LIMIT);
  assign sts_o.cur_ok     = cur_q < LinkW'(TABLE_DEPTH);
  assign sts_o.steps_over = steps_q >= SW'(TABLE_DEPTH);

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  // The port is single: never a read and a write together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  // A scanned entry under check always lies inside the scan bound
  assert property (@(posedge clk_i) disable iff (!rst_ni) chk_valid_q |-> chk_addr_q < scan_end_q)
    else $error("checked scan address beyond scan bound");

  // A strobe follows only a finishing command
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(cmd_i.finish))
    else $error("result strobe without finish");

endmodule

[hw/rtl/fcte_ctrl.sv]
// Controller state machine sequencing reads, writes, allocate scans and chain frees.
`timescale 1ns / 1ps

module fcte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  fcte_pkg::fcte_sts_t sts_i,
  output fcte_pkg::fcte_cmd_t cmd_o
);
  import fcte_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_RD_WAIT  = 6'b000100,
    S_SCAN     = 6'b001000,
    S_FREE_CHK = 6'b010000,
    S_FREE_WR  = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  fcte_cmd_t cmd;

  // Next state and command decode
  always_comb begin
    state_d       = state_q;
    cmd           = '0;
    cmd.mem_op    = MEM_NONE;
    cmd.res_sel   = RES_ZERO;
    cmd.status    = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.req_kind)
          REQ_READ: begin
            if (sts_i.idx_ok) begin
              cmd.mem_op = MEM_READ_IDX;
              state_d    = S_RD_WAIT;
            end else begin
              cmd.finish = 1'b1;
              cmd.status = ST_RANGE;
              state_d    = S_IDLE;
            end
          end
          REQ_WRITE: begin
            cmd.finish = 1'b1;
            state_d    = S_IDLE;
            if (sts_i.idx_ok) begin
              cmd.mem_op = MEM_WRITE_IDX;
            end else begin
              cmd.status = ST_RANGE;
            end
          end
          REQ_ALLOC: begin
            cmd.scan_init = 1'b1;
            state_d       = S_SCAN;
          end
          REQ_FREE: begin
            cmd.free_init = 1'b1;
            state_d       = S_FREE_CHK;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.finish  = 1'b1;
        cmd.res_sel = RES_RDATA;
        state_d     = S_IDLE;
      end
      // One entry read per cycle; the entry read last cycle is checked now
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          cmd.mem_op  = MEM_WRITE_EOC;
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_ALLOC;
          state_d     = S_IDLE;
        end else if (sts_i.scan_more) begin
          cmd.mem_op = MEM_READ_SCAN;
        end else if (!sts_i.chk_valid) begin
          cmd.finish = 1'b1;
          cmd.status = sts_i.clipped ? ST_RANGE : ST_OK;
          state_d    = S_IDLE;
        end
      end
      S_FREE_CHK: begin
        if (!sts_i.cur_live) begin
          cmd.finish = 1'b1;
          state_d    = S_IDLE;
        end else if (!sts_i.cur_ok) begin
          cmd.finish = 1'b1;
          cmd.status = ST_RANGE;
          state_d    = S_IDLE;
        end else if (sts_i.steps_over) begin
          cmd.finish = 1'b1;
          cmd.status = ST_LOOP;
          state_d    = S_IDLE;
        end else begin
          cmd.mem_op = MEM_READ_CUR;
          state_d    = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        cmd.mem_op = MEM_WRITE_ZERO;
        state_d    = S_FREE_CHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy  = (state_q != S_IDLE);
  assign cmd_o = cmd;

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");

  // An accepted transaction is always decoded next
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> state_q == S_DECODE)
    else $error("accepted transaction not decoded");

  // Finishing always returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.finish |=> state_q == S_IDLE)
    else $error("finish without return to idle");

endmodule

[hw/rtl/fat_cluster_table_engine.sv]
// Top level of the cluster allocation table engine.
`timescale 1ns / 1ps

// One transaction at a time is taken while busy is low and answered by exactly one
// result, shown on rsp_o for the single cycle in which done_o is high; the receiver
// cannot hold it off. A write is done in S_DECODE; a read is issued there and
// finished in S_RD_WAIT. An allocate reads one entry per cycle and checks it on the
// next, pipelined on the table's registered read; it ends at the first free entry,
// after checking the last entry when none is free, or with no read if the range is
// empty. A free reads and clears each chain entry in turn (S_FREE_CHK, S_FREE_WR)
// on the single table port. busy drops in the strobe cycle, so the next transaction
// may start there. Table contents are undefined after reset; software loads every
// entry before use, and no clearing pass is run. The user writes data_cluster_count
// through cfg_we_i/cfg_data_i only while busy is low; the block does not enforce it.
module fat_cluster_table_engine #(
  parameter int unsigned TABLE_DEPTH = 16384
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  fcte_pkg::fcte_req_t         req_i,
  input  logic                        cfg_we_i,
  input  logic [fcte_pkg::CountW-1:0] cfg_data_i,
  output fcte_pkg::fcte_rsp_t         rsp_o,
  output logic                        done_o
);
  import fcte_pkg::*;

  fcte_cmd_t cmd;
  fcte_sts_t sts;

  fcte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  fcte_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o),
    .done_o     (done_o)
  );

endmodule
